FILE: rtl/frsn_pkg.sv
`default_nettype none

package frsn_pkg;

    localparam int LENGTH_BITS_DEF = 24;
    localparam int RECORD_BITS_DEF = 16;

    // fixed widths of the result fields on the port
    localparam int REC_OUT_W = 16;
    localparam int LEN_OUT_W = 24;

    localparam int OQ_DEPTH   = 8;
    localparam int MAX_RESULT = 3;

    typedef enum logic [1:0] {
        KIND_BASE = 2'd0,
        KIND_END  = 2'd1,
        KIND_DONE = 2'd2,
        KIND_ERR  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_SEQ   = 2'd1,
        PH_SKIP  = 2'd2
    } phase_t;

    localparam logic [2:0] ERR_BAD_SYMBOL  = 3'd0;
    localparam logic [2:0] ERR_HEADER_ONLY = 3'd1;
    localparam logic [2:0] ERR_NO_SEQ      = 3'd2;
    localparam logic [2:0] ERR_NO_IDENT    = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW    = 3'd4;

    localparam logic [2:0] BASE_A = 3'd0;
    localparam logic [2:0] BASE_C = 3'd1;
    localparam logic [2:0] BASE_G = 3'd2;
    localparam logic [2:0] BASE_U = 3'd3;
    localparam logic [2:0] BASE_N = 3'd4;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_HEADER = 8'h3E;
    localparam logic [7:0] CH_COMMENT = 8'h3B;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CASE_DIFF = 8'h20;

    typedef struct packed {
        phase_t phase;
        logic   header_open;
        logic   err;
    } ctl_t;

    typedef struct packed {
        kind_t          kind;
        logic [2:0]     base_code;
        logic [REC_OUT_W-1:0] record_number;
        logic [LEN_OUT_W-1:0] record_length;
        logic           had_header;
        logic [2:0]     err_code;
        logic           last;
    } res_t;

    // bit 3 set means the byte is rejected
    function automatic logic [3:0] base_of(input logic [7:0] b);
        logic [7:0] u;
        logic [3:0] code;
        u = b;
        if (b >= CH_LOW_A && b <= CH_LOW_Z)
        begin
            u = b - CASE_DIFF;
        end
        unique case (u)
            "A": code = {1'b0, BASE_A};
            "C": code = {1'b0, BASE_C};
            "G": code = {1'b0, BASE_G};
            "T", "U": code = {1'b0, BASE_U};
            "R", "Y", "S", "W", "K", "M", "B", "D", "H", "V", "N":
                code = {1'b0, BASE_N};
            default: code = 4'b1000;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/frsn_step.sv
`default_nettype none

module frsn_step
    import frsn_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF,
    parameter int RECORD_BITS = RECORD_BITS_DEF
)
(
    input  wire logic [7:0]             byte_in,
    input  wire logic                   eos,
    input  wire ctl_t                   ctl,
    input  wire logic [LENGTH_BITS-1:0] base_count,
    input  wire logic [RECORD_BITS-1:0] records_done,
    output ctl_t                        ctl_next,
    output logic [LENGTH_BITS-1:0]      base_count_next,
    output logic [RECORD_BITS-1:0]      records_done_next,
    output res_t                        res [MAX_RESULT],
    output logic [1:0]                  res_n
);

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
    localparam logic [RECORD_BITS-1:0] REC_MAX = {RECORD_BITS{1'b1}};

    logic                   ws;
    logic [3:0]             code;

    always_comb
    begin
        ws   = (byte_in == CH_SPACE) || (byte_in >= CH_TAB && byte_in <= CH_CR);
        code = base_of(byte_in);
    end

    // results append in order; a byte closes at most one record
    always_comb
    begin
        phase_t                 ph;
        logic                   ho;
        logic                   er;
        logic [LENGTH_BITS-1:0] bc;
        logic [RECORD_BITS-1:0] rd;
        logic [1:0]             n;
        logic                   take;

        ph   = ctl.phase;
        ho   = ctl.header_open;
        er   = ctl.err;
        bc   = base_count;
        rd   = records_done;
        n    = 2'd0;
        take = 1'b0;
        for (int i = 0; i < MAX_RESULT; i++)
        begin
            res[i] = '0;
        end

        if (!er)
        begin
            if (byte_in == CH_NL)
            begin
                ph = PH_START;
            end
            else
            begin
                unique case (ph)
                    PH_START:
                    begin
                        if (!ws)
                        begin
                            if (byte_in == CH_HEADER)
                            begin
                                // header closes the record before it
                                if (bc == '0)
                                begin
                                    if (ho)
                                    begin
                                        er = 1'b1;
                                        res[n] = '{KIND_ERR, 3'd0,
                                                   REC_OUT_W'(rd + 1'b1),
                                                   LEN_OUT_W'(bc), ho,
                                                   ERR_HEADER_ONLY, 1'b0};
                                        n = n + 2'd1;
                                    end
                                end
                                else
                                begin
                                    res[n] = '{KIND_END, 3'd0, REC_OUT_W'(rd + 1'b1),
                                               LEN_OUT_W'(bc), ho, 3'd0, 1'b0};
                                    n  = n + 2'd1;
                                    rd = rd + 1'b1;
                                    bc = '0;
                                end
                                ho = 1'b1;
                                ph = PH_SKIP;
                            end
                            else if (byte_in == CH_COMMENT)
                            begin
                                ph = PH_SKIP;
                            end
                            else
                            begin
                                ph   = PH_SEQ;
                                take = 1'b1;
                            end
                        end
                    end
                    PH_SEQ:
                    begin
                        take = !ws;
                    end
                    PH_SKIP:
                    begin
                        take = 1'b0;
                    end
                    default:
                    begin
                        ph = PH_START;
                    end
                endcase
            end

            if (take)
            begin
                if (code[3])
                begin
                    er = 1'b1;
                    res[n] = '{KIND_ERR, 3'd0, REC_OUT_W'(rd + 1'b1), LEN_OUT_W'(bc),
                               ho, ERR_BAD_SYMBOL, 1'b0};
                    n = n + 2'd1;
                end
                else if (bc == LEN_MAX || rd == REC_MAX)
                begin
                    er = 1'b1;
                    res[n] = '{KIND_ERR, 3'd0, REC_OUT_W'(rd + 1'b1), LEN_OUT_W'(bc),
                               ho, ERR_OVERFLOW, 1'b0};
                    n = n + 2'd1;
                end
                else
                begin
                    bc = bc + 1'b1;
                    res[n] = '{KIND_BASE, code[2:0], REC_OUT_W'(rd + 1'b1),
                               LEN_OUT_W'(0), ho, 3'd0, 1'b0};
                    n = n + 2'd1;
                end
            end

            if (!er && eos)
            begin
                if (bc == '0)
                begin
                    if (ho)
                    begin
                        er = 1'b1;
                        res[n] = '{KIND_ERR, 3'd0, REC_OUT_W'(rd + 1'b1), LEN_OUT_W'(bc),
                                   ho, ERR_HEADER_ONLY, 1'b0};
                        n = n + 2'd1;
                    end
                end
                else
                begin
                    res[n] = '{KIND_END, 3'd0, REC_OUT_W'(rd + 1'b1), LEN_OUT_W'(bc),
                               ho, 3'd0, 1'b0};
                    n  = n + 2'd1;
                    rd = rd + 1'b1;
                    bc = '0;
                end

                if (!er)
                begin
                    if (rd == '0)
                    begin
                        er = 1'b1;
                        res[n] = '{KIND_ERR, 3'd0, REC_OUT_W'(rd + 1'b1), LEN_OUT_W'(bc),
                                   ho, ERR_NO_SEQ, 1'b0};
                        n = n + 2'd1;
                    end
                    else
                    begin
                        res[n] = '{KIND_DONE, 3'd0, REC_OUT_W'(rd), LEN_OUT_W'(0),
                                   1'b0, 3'd0, 1'b0};
                        n  = n + 2'd1;
                        // stream done: back to reset for the next stream
                        ph = PH_START;
                        ho = 1'b0;
                        bc = '0;
                        rd = '0;
                    end
                end
            end

            if (n != 2'd0)
            begin
                res[n - 2'd1].last = 1'b1;
            end
        end

        ctl_next          = '{ph, ho, er};
        base_count_next   = bc;
        records_done_next = rd;
        res_n             = n;
    end

endmodule

`default_nettype wire

FILE: rtl/frsn_outq.sv
`default_nettype none

module frsn_outq
    import frsn_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic [1:0] push_n,
    input  wire res_t push_data [MAX_RESULT],
    input  wire logic pop,
    output res_t      head,
    output logic      not_empty,
    output logic      room
);

    localparam int PTR_W = $clog2(OQ_DEPTH);
    localparam int CNT_W = $clog2(OQ_DEPTH + 1);

    res_t             mem [OQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_pop;

    always_comb
    begin
        do_pop      = pop && (count_reg != '0);
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + PTR_W'(do_pop);
        count_next  = count_reg + CNT_W'(push_n) - CNT_W'(do_pop);
        head        = mem[rd_ptr_reg];
        not_empty   = (count_reg != '0);
        // room for the worst case of one byte
        room        = (count_reg <= CNT_W'(OQ_DEPTH - MAX_RESULT));
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULT; i++)
        begin
            if (i < int'(push_n))
            begin
                mem[wr_ptr_reg + PTR_W'(i)] <= push_data[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    overflow_chk: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(OQ_DEPTH))
        else $error("output queue over capacity");

    push_room_chk: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n != 2'd0) |-> (count_reg <= CNT_W'(OQ_DEPTH - MAX_RESULT)))
        else $error("push without room for a full byte");

    pop_order_chk: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && push_n == 2'd0) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not drain one entry");

endmodule

`default_nettype wire

FILE: rtl/fasta_rna_stream_normalizer.sv
`default_nettype none

// channel   dir  handshake          payload
// s_*       in   tvalid/tready      tdata: data_byte, tlast: end_of_stream
// m_*       out  tvalid/tready      tdata: result fields, tuser: kind, tlast: last
// cfg_*     in   cfg_valid/ready    cfg_data: fallback_name_empty
//
// a byte is held in the input register, then its 0..3 results enter an 8-entry output
// queue that drives m_*; one byte per cycle while the queue holds at most 5 results;
// results leave one per cycle while m_tready is high; rst_n clears line state,
// counters, error flag and the queue; cfg_ready is always high
// after an error no results come until reset, end_of_stream included

module fasta_rna_stream_normalizer
    import frsn_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF,
    parameter int RECORD_BITS = RECORD_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // end_of_stream

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [2:0] base_code, [18:3] record_number, [42:19] record_length,
    // [43] had_header, [46:44] err_code, [47] zero
    output logic [47:0]      m_tdata,
    output logic [1:0]       m_tuser,   // [1:0] kind
    output logic             m_tlast,   // last

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data   // fallback_name_empty
);

    logic                   in_vld_reg;
    logic [7:0]             byte_reg;
    logic                   eos_reg;

    ctl_t                   ctl_reg;
    ctl_t                   ctl_next;
    logic [LENGTH_BITS-1:0] base_count_reg;
    logic [LENGTH_BITS-1:0] base_count_next;
    logic [RECORD_BITS-1:0] records_done_reg;
    logic [RECORD_BITS-1:0] records_done_next;
    logic                   fallback_reg;

    res_t                   step_res [MAX_RESULT];
    logic [1:0]             step_n;
    logic [1:0]             push_n;
    logic                   room;
    logic                   adv;
    res_t                   head;

    frsn_step #(
        .LENGTH_BITS (LENGTH_BITS),
        .RECORD_BITS (RECORD_BITS)
    ) u_step (
        .byte_in           (byte_reg),
        .eos               (eos_reg),
        .ctl               (ctl_reg),
        .base_count        (base_count_reg),
        .records_done      (records_done_reg),
        .ctl_next          (ctl_next),
        .base_count_next   (base_count_next),
        .records_done_next (records_done_next),
        .res               (step_res),
        .res_n             (step_n)
    );

    frsn_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .push_data (step_res),
        .pop       (m_tready),
        .head      (head),
        .not_empty (m_tvalid),
        .room      (room)
    );

    always_comb
    begin
        adv       = in_vld_reg && room;
        push_n    = adv ? step_n : 2'd0;
        s_tready  = !in_vld_reg || room;
        cfg_ready = 1'b1;
        m_tdata   = {1'b0, head.err_code, head.had_header, head.record_length,
                     head.record_number, head.base_code};
        m_tuser   = head.kind;
        m_tlast   = head.last;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg <= s_tdata;
            eos_reg  <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg       <= 1'b0;
            ctl_reg          <= '{PH_START, 1'b0, 1'b0};
            base_count_reg   <= '0;
            records_done_reg <= '0;
            fallback_reg     <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_vld_reg <= s_tvalid;
            end
            if (adv)
            begin
                ctl_reg          <= ctl_next;
                base_count_reg   <= base_count_next;
                records_done_reg <= records_done_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                fallback_reg <= cfg_data;
            end
        end
    end

    // the step never emits ERR_NO_IDENT, so the identifier check never fires
    no_ident_chk: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_ERR) |-> (m_tdata[46:44] != ERR_NO_IDENT
            || fallback_reg))
        else $error("identifier error emitted");

    err_quiet_chk: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.err |-> (push_n == 2'd0))
        else $error("results after a latched error");

    done_clear_chk: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && step_n != 2'd0 && step_res[step_n - 2'd1].kind == KIND_DONE)
            |=> (records_done_reg == '0 && base_count_reg == '0))
        else $error("counters not cleared after stream done");

    stall_hold_chk: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !room) |=> (in_vld_reg && $stable(byte_reg) && $stable(eos_reg)))
        else $error("held byte lost while queue full");

endmodule

`default_nettype wire
